@@ hw/rtl/u64dec_pkg.sv @@
// shared constants and types for the binary to padded decimal ascii converter
package u64dec_pkg;

  localparam int DEC_DIGITS     = 20;
  localparam int DIG_IDX_W      = $clog2(DEC_DIGITS);
  localparam int CNT_W          = 5;
  localparam int CHAR_W         = 8;
  localparam int VALUE_W        = 64;
  localparam int MAX_DIGITS_DEF = 20;
  localparam int VALUE_BITS_DEF = 64;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;

  typedef logic [DEC_DIGITS-1:0][3:0] bcd_digits_t;

endpackage

@@ hw/rtl/u64dec_bcd.sv @@
// iterative shift-and-add-3 binary to bcd converter, one input bit per cycle
module u64dec_bcd
  import u64dec_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  done,
  output bcd_digits_t           digits
);

  localparam int                STEP_W   = $clog2(VALUE_BITS + 1);
  localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1);

  logic [VALUE_BITS-1:0]   bin_r, bin_nxt;
  bcd_digits_t             bcd_r, bcd_nxt;
  bcd_digits_t             corr;
  logic [4*DEC_DIGITS-1:0] corr_flat;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic                    done_r, done_nxt;

  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      corr[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  assign corr_flat = corr;

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = value;
      bcd_nxt  = '0;
      step_nxt = STEP_W'(VALUE_BITS);
    end else if (step_r != '0) begin
      bin_nxt  = {bin_r[VALUE_BITS-2:0], 1'b0};
      bcd_nxt  = {corr_flat[4*DEC_DIGITS-2:0], bin_r[VALUE_BITS-1]};
      step_nxt = step_r - STEP_ONE;
      done_nxt = (step_r == STEP_ONE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done   = done_r;
  assign digits = bcd_r;

endmodule

@@ hw/rtl/u64dec_emit.sv @@
// sequencer: input handshake, digit count, character emission and output register
module u64dec_emit
  import u64dec_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CNT_W-1:0]  field_width,
  input  logic              pad_with_space,
  output logic              bcd_start,
  input  logic              bcd_done,
  input  bcd_digits_t       digits,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [CHAR_W-1:0] char_out,
  output logic              last,
  output logic              truncated,
  output logic [CNT_W-1:0]  digit_count
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CONV  = 2'd1;
  localparam logic [1:0] ST_COUNT = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic [CNT_W-1:0] MAX_EMIT = CNT_W'(MAX_DIGITS);

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    width_r, width_nxt;
  logic                pad_r, pad_nxt;
  logic [CNT_W-1:0]    natural_r, natural_nxt;
  logic                trunc_r, trunc_nxt;
  logic [DIG_IDX_W-1:0] pos_r, pos_nxt;
  logic                ov_r, ov_nxt;
  logic [CHAR_W-1:0]   char_r, char_nxt;
  logic                last_r, last_nxt;
  logic                otrunc_r, otrunc_nxt;
  logic [CNT_W-1:0]    ocnt_r, ocnt_nxt;

  logic [CNT_W-1:0]    natural;
  logic [CNT_W-1:0]    emit_len;
  logic                accept;
  logic                load;
  logic [CHAR_W-1:0]   digit_char;

  always_comb begin
    natural = CNT_W'(1);
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (digits[i] != 4'd0) begin
        natural = CNT_W'(i + 1);
      end
    end
  end

  always_comb begin
    emit_len = (width_r == '0) ? natural : width_r;
    if (emit_len > MAX_EMIT) begin
      emit_len = MAX_EMIT;
    end
  end

  assign accept     = in_tvalid && (state_r == ST_IDLE);
  assign load       = (state_r == ST_EMIT) && (!ov_r || out_tready);
  assign digit_char = ASCII_ZERO + {4'b0000, digits[pos_r]};

  always_comb begin
    state_nxt   = state_r;
    width_nxt   = width_r;
    pad_nxt     = pad_r;
    natural_nxt = natural_r;
    trunc_nxt   = trunc_r;
    pos_nxt     = pos_r;
    ov_nxt      = ov_r;
    char_nxt    = char_r;
    last_nxt    = last_r;
    otrunc_nxt  = otrunc_r;
    ocnt_nxt    = ocnt_r;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          width_nxt = field_width;
          pad_nxt   = pad_with_space;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bcd_done) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        natural_nxt = natural;
        trunc_nxt   = (natural > emit_len);
        pos_nxt     = DIG_IDX_W'(emit_len - CNT_W'(1));
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (load) begin
          ov_nxt     = 1'b1;
          char_nxt   = (CNT_W'(pos_r) < natural_r) ? digit_char
                     : (pad_r ? ASCII_SPACE : ASCII_ZERO);
          last_nxt   = (pos_r == '0);
          otrunc_nxt = trunc_r;
          ocnt_nxt   = natural_r;
          if (pos_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt = pos_r - DIG_IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    width_r   <= width_nxt;
    pad_r     <= pad_nxt;
    natural_r <= natural_nxt;
    trunc_r   <= trunc_nxt;
    pos_r     <= pos_nxt;
    char_r    <= char_nxt;
    last_r    <= last_nxt;
    otrunc_r  <= otrunc_nxt;
    ocnt_r    <= ocnt_nxt;
  end

  assign in_tready   = (state_r == ST_IDLE);
  assign bcd_start   = accept;
  assign out_tvalid  = ov_r;
  assign char_out    = char_r;
  assign last        = last_r;
  assign truncated   = otrunc_r;
  assign digit_count = ocnt_r;

endmodule

@@ hw/rtl/uint64_to_padded_decimal_ascii.sv @@
// top level: unsigned binary to padded decimal ascii character stream
// path from input transfer to first character: bit-serial bcd conversion, digit count, output register,
// then one character per cycle while out_tready stays high
// a new item is accepted only after the previous item's last character is loaded for output
// rst_n is synchronous, active low; clears the sequencer and the output valid
module uint64_to_padded_decimal_ascii
  import u64dec_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // value[63:0], field_width[68:64], pad_with_space[69], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // char_out[7:0], digit_count[12:8], zero
  output logic        out_tlast,
  output logic        out_tuser   // truncated
);

  logic              bcd_start;
  logic              bcd_done;
  bcd_digits_t       digits;
  logic [CHAR_W-1:0] char_out;
  logic [CNT_W-1:0]  digit_count;

  u64dec_bcd #(
    .VALUE_BITS(VALUE_BITS)
  ) u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bcd_start),
    .value (in_tdata[VALUE_BITS-1:0]),
    .done  (bcd_done),
    .digits(digits)
  );

  u64dec_emit #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .field_width   (in_tdata[VALUE_W +: CNT_W]),
    .pad_with_space(in_tdata[VALUE_W + CNT_W]),
    .bcd_start     (bcd_start),
    .bcd_done      (bcd_done),
    .digits        (digits),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .char_out      (char_out),
    .last          (out_tlast),
    .truncated     (out_tuser),
    .digit_count   (digit_count)
  );

  assign out_tdata = {3'b000, digit_count, char_out};

endmodule

@@ verif/tb_top.sv @@
// testbench: directed, random, backpressure, back-to-back items; each char checked against a predictor
module tb_top;
  import u64dec_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int LONG_HOLD    = 600;
  localparam int RANDOM_ITEMS = 300;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              trunc;
    logic [CNT_W-1:0]  count;
  } ascii_char_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  ascii_char_t pending_chars[$];
  int          error_count     = 0;
  int          cycle_count     = 0;
  int          sent_count      = 0;
  int          chars_checked   = 0;
  int          truncated_seen  = 0;
  int          hold_requests   = 0;
  int          holds_done      = 0;
  bit          no_idle         = 1'b0;

  uint64_to_padded_decimal_ascii DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int decimal_length(input logic [63:0] value);
    int n;
    n = 1;
    while (value >= 64'd10) begin
      value = value / 64'd10;
      n++;
    end
    return n;
  endfunction

  function automatic logic [63:0] pow10(input int k);
    logic [63:0] p;
    p = 64'd1;
    repeat (k) p = p * 64'd10;
    return p;
  endfunction

  // decimal text of one conversion, most significant character first
  function automatic void predict_text(input logic [63:0] value, input logic [4:0] width,
                                       input logic pad_space);
    logic [3:0]  digs [DEC_DIGITS];
    logic [63:0] rest;
    int          ndig;
    int          emit;
    int          pos;
    int          k;
    ascii_char_t c;
    ndig = decimal_length(value);
    rest = value;
    for (k = 0; k < ndig; k++) begin
      digs[k] = 4'(rest % 64'd10);
      rest = rest / 64'd10;
    end
    emit = (width == 0) ? ndig : int'(width);
    if (emit > MAX_DIGITS_DEF) emit = MAX_DIGITS_DEF;
    for (k = 0; k < emit; k++) begin
      pos     = emit - 1 - k;
      c.ch    = (pos < ndig) ? ASCII_ZERO + 8'(digs[pos])
                             : (pad_space ? ASCII_SPACE : ASCII_ZERO);
      c.last  = (k == emit - 1);
      c.trunc = (ndig > emit);
      c.count = CNT_W'(ndig);
      pending_chars.push_back(c);
    end
  endfunction

  task automatic send_conversion(input logic [63:0] value, input logic [4:0] width,
                                 input logic pad_space);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {2'b00, pad_space, width, value};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_text(value, width, pad_space);
    sent_count++;
  endtask

  function automatic logic [63:0] random_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return pow10($urandom_range(0, 19)) - 64'($urandom_range(0, 1));
    if (r < 3) return $urandom_range(0, 1) ? '1 : 64'($urandom_range(0, 9));
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  function automatic logic [4:0] random_width(input logic [63:0] value);
    int n;
    n = decimal_length(value) + $urandom_range(0, 4) - 2;
    case ($urandom_range(0, 3))
      0:       return 5'd0;
      3:       return 5'($urandom_range(0, 31));
      default: return 5'((n < 1) ? 1 : n);
    endcase
  endfunction

  task automatic test_directed();
    send_conversion(64'd0, 5'd0, 1'b0);
    send_conversion(64'd0, 5'd5, 1'b1);
    send_conversion(64'd0, 5'd1, 1'b0);
    send_conversion(64'd1, 5'd0, 1'b0);
    send_conversion(64'd9, 5'd3, 1'b0);
    send_conversion(64'd10, 5'd2, 1'b1);
    send_conversion(64'd99, 5'd1, 1'b0);
    send_conversion(64'd100, 5'd0, 1'b0);
    send_conversion(64'd12345, 5'd8, 1'b1);
    send_conversion(64'd12345, 5'd8, 1'b0);
    send_conversion(64'd12345, 5'd3, 1'b0);
    send_conversion(64'd12345, 5'd5, 1'b1);
    send_conversion('1, 5'd0, 1'b0);
    send_conversion('1, 5'd20, 1'b1);
    send_conversion('1, 5'd19, 1'b0);
    send_conversion('1, 5'd1, 1'b1);
    send_conversion(pow10(19), 5'd0, 1'b0);
    send_conversion(pow10(19) - 1, 5'd0, 1'b0);
    send_conversion(pow10(19) - 1, 5'd20, 1'b1);
    send_conversion(64'd42, 5'd31, 1'b1);
    send_conversion(64'd42, 5'd21, 1'b0);
    send_conversion(64'd7, 5'd20, 1'b0);
    send_conversion(64'hAAAA_AAAA_AAAA_AAAA, 5'd0, 1'b0);
    send_conversion(64'h5555_5555_5555_5555, 5'd25, 1'b1);
  endtask

  task automatic test_random();
    logic [63:0] v;
    repeat (RANDOM_ITEMS) begin
      v = random_value();
      send_conversion(v, random_width(v), 1'($urandom_range(0, 1)));
    end
  endtask

  // receiver stops for a long stretch while items keep coming
  task automatic test_backpressure();
    logic [63:0] v;
    hold_requests++;
    repeat (12) begin
      v = random_value();
      send_conversion(v, 5'($urandom_range(16, 20)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_back_to_back();
    logic [63:0] v;
    no_idle = 1'b1;
    repeat (30) begin
      v = random_value();
      send_conversion(v, random_width(v), 1'($urandom_range(0, 1)));
    end
    no_idle = 1'b0;
  endtask

  initial begin : ready_driver
    int gap;
    @(posedge clk);
    forever begin
      if (holds_done != hold_requests) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    ascii_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        $error("character transfer with nothing pending: char 0x%02h", out_tdata[7:0]);
        error_count++;
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (out_tdata[7:0] !== want.ch) begin
          $error("char_out: expected 0x%02h, got 0x%02h", want.ch, out_tdata[7:0]);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_tlast);
          error_count++;
        end
        if (out_tuser !== want.trunc) begin
          $error("truncated: expected %0b, got %0b", want.trunc, out_tuser);
          error_count++;
        end
        if (out_tdata[12:8] !== want.count) begin
          $error("digit_count: expected %0d, got %0d", want.count, out_tdata[12:8]);
          error_count++;
        end
        if (want.last && want.trunc) truncated_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d characters pending", cycle_count,
               pending_chars.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    test_back_to_back();
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (VALUE_BITS_DEF + 8) @(posedge clk);
    $display("ran %0d conversions, %0d characters checked, %0d with truncation",
             sent_count, chars_checked, truncated_seen);
    $display("widths 0..31 with both pad choices, including a long output stall");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
